### sv/uuidp_pkg.sv
package uuidp_pkg;

    localparam int unsigned TEXT_LEN = 36;
    localparam logic [5:0] POS_LAST = 6'(TEXT_LEN - 1);
    localparam logic [5:0] POS_MAX = 6'd63;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] VARIANT_MASK = 8'hC0;
    localparam logic [7:0] VARIANT_RFC = 8'h80;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FORM = 2'd1;
    localparam logic [1:0] STATUS_DIGIT = 2'd2;
    localparam logic [1:0] STATUS_INVALID = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] uuid_high;
        logic [63:0] uuid_low;
        logic [3:0]  version_nibble;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic       past_end;
        logic       hyphen_slot;
        logic       is_hyphen;
        logic       is_hex;
        logic [3:0] nibble;
        logic       low_nibble;
    } char_class_t;

    function automatic logic is_hyphen_slot(input logic [5:0] pos);
        return (pos == 6'd8) || (pos == 6'd13) || (pos == 6'd18) || (pos == 6'd23);
    endfunction

    // Second digit of a byte: parity of the digit index, adjusted per group.
    function automatic logic is_low_nibble(input logic [5:0] pos);
        logic r;
        begin
            if (pos < 6'd8) begin
                r = pos[0];
            end else if (pos < 6'd13) begin
                r = ~pos[0];
            end else if (pos < 6'd18) begin
                r = pos[0];
            end else if (pos < 6'd23) begin
                r = ~pos[0];
            end else begin
                r = pos[0];
            end
            return r;
        end
    endfunction

endpackage

### sv/uuidp_char_dec.sv
module uuidp_char_dec (
    input  logic [7:0]                char_code,
    input  logic [5:0]                pos,
    output uuidp_pkg::char_class_t    cls
);

    always_comb begin
        cls.past_end    = (pos >= 6'(uuidp_pkg::TEXT_LEN));
        cls.hyphen_slot = uuidp_pkg::is_hyphen_slot(pos);
        cls.is_hyphen   = (char_code == uuidp_pkg::CHAR_HYPHEN);
        cls.low_nibble  = uuidp_pkg::is_low_nibble(pos);
        if (char_code inside {[8'h30:8'h39]}) begin
            cls.is_hex = 1'b1;
            cls.nibble = char_code[3:0];
        end else if (char_code inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            cls.is_hex = 1'b1;
            cls.nibble = char_code[3:0] + uuidp_pkg::HEX_ALPHA_OFS;
        end else begin
            cls.is_hex = 1'b0;
            cls.nibble = 4'd0;
        end
    end

endmodule

### sv/uuidp_accum.sv
module uuidp_accum (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   last,
    input  uuidp_pkg::char_class_t cls,
    output logic [5:0]             pos,
    output uuidp_pkg::out_item_t   result
);

    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  pend_reg, pend_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] lo_reg, lo_next;
    logic        form_reg, form_next;
    logic        digit_reg, digit_next;
    logic        nz_reg, nz_next;
    logic        digit_slot;
    logic [3:0]  version;
    logic        ver_ok;
    logic        var_ok;

    assign pos = pos_reg;
    assign digit_slot = !cls.past_end && !cls.hyphen_slot;

    always_comb begin
        pend_next  = pend_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        pos_next   = (pos_reg == uuidp_pkg::POS_MAX) ? pos_reg : pos_reg + 6'd1;
        form_next  = form_reg || cls.past_end || (cls.hyphen_slot && !cls.is_hyphen)
                     || (last && pos_reg != uuidp_pkg::POS_LAST);
        digit_next = digit_reg || (digit_slot && !cls.is_hex);
        nz_next    = nz_reg || (digit_slot && cls.nibble != 4'd0);
        if (digit_slot) begin
            if (cls.low_nibble) begin
                hi_next   = {hi_reg[55:0], lo_reg[63:56]};
                lo_next   = {lo_reg[55:0], pend_reg, cls.nibble};
                pend_next = 4'd0;
            end else begin
                pend_next = cls.nibble;
            end
        end
    end

    always_comb begin
        version = hi_next[15:12];
        ver_ok  = (version inside {4'd1, [4'd3:4'd8]});
        var_ok  = ((lo_next[63:56] & uuidp_pkg::VARIANT_MASK) == uuidp_pkg::VARIANT_RFC);
        result.uuid_high      = hi_next;
        result.uuid_low       = lo_next;
        result.version_nibble = version;
        if (form_next) begin
            result.status = uuidp_pkg::STATUS_FORM;
        end else if (digit_next) begin
            result.status = uuidp_pkg::STATUS_DIGIT;
        end else if (nz_next && ver_ok && var_ok) begin
            result.status = uuidp_pkg::STATUS_OK;
        end else begin
            result.status = uuidp_pkg::STATUS_INVALID;
        end
        if (form_next || digit_next) begin
            result.uuid_high      = 64'd0;
            result.uuid_low       = 64'd0;
            result.version_nibble = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last)) begin
            pos_reg   <= 6'd0;
            pend_reg  <= 4'd0;
            hi_reg    <= 64'd0;
            lo_reg    <= 64'd0;
            form_reg  <= 1'b0;
            digit_reg <= 1'b0;
            nz_reg    <= 1'b0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            pend_reg  <= pend_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            form_reg  <= form_next;
            digit_reg <= digit_next;
            nz_reg    <= nz_next;
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last |=> pos_reg == 6'd0 && !form_reg && !digit_reg && !nz_reg)
        else $error("state not cleared after last item");

    a_form_past_end: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg > 6'(uuidp_pkg::TEXT_LEN) |-> form_reg)
        else $error("position past end without form error");

endmodule

### sv/uuid_text_parser_top.sv
// UUID text parser.
// Input channel s_*: one character per item in s_item.char_code, with
// s_item.last set on the final character of each UUID string.
// Output channel m_*: one result item per string, carrying the 128-bit value
// (uuid_high, uuid_low), the version nibble and a status code
// (0 ok, 1 bad length or hyphen, 2 non-hex digit, 3 nil or bad
// variant/version). Characters without last produce no item.
// Output: the result appears on m_valid in the cycle after the item carrying
// last is accepted. Throughput: one character per cycle while s_ready is
// high; per-character work is a hex decode and a byte shift done between the
// state registers and the result register.
// Stall: while a result waits with m_ready low, s_ready drops; when m_ready
// is high the next character is taken in the same cycle the result leaves.
// Reset (aresetn low, synchronous): position, error flags and the value
// shift register clear and m_valid drops; the parser starts a new string.
module uuid_text_parser_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  uuidp_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output uuidp_pkg::out_item_t m_item
);

    logic                   accept;
    logic [5:0]             pos;
    uuidp_pkg::char_class_t cls;
    uuidp_pkg::out_item_t   result;
    logic                   m_valid_reg;
    uuidp_pkg::out_item_t   m_item_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    uuidp_char_dec u_dec (
        .char_code (s_item.char_code),
        .pos       (pos),
        .cls       (cls)
    );

    uuidp_accum u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .last    (s_item.last),
        .cls     (cls),
        .pos     (pos),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_item.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_item.last) begin
            m_item_reg <= result;
        end
    end

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.last |=> m_valid)
        else $error("no result after last item");

    a_error_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == uuidp_pkg::STATUS_FORM
                    || m_item.status == uuidp_pkg::STATUS_DIGIT)
        |-> m_item.uuid_high == 64'd0 && m_item.uuid_low == 64'd0
            && m_item.version_nibble == 4'd0)
        else $error("error result carries a value");

    a_ok_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == uuidp_pkg::STATUS_OK
        |-> m_item.uuid_low[63:62] == 2'b10 && m_item.version_nibble != 4'd0
            && m_item.version_nibble != 4'd2 && m_item.version_nibble < 4'd9)
        else $error("ok status on invalid variant or version");

endmodule

### test/uuid_text_parser_checker.sv
module uuid_text_parser_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  uuidp_pkg::in_item_t  s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  uuidp_pkg::out_item_t m_item,
    output int                   fail_count,
    output int                   expected_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser state as predicted
    logic [5:0]  char_pos;
    logic [3:0]  high_nib;
    logic [63:0] bytes_hi;
    logic [63:0] bytes_lo;
    logic        bad_form;
    logic        bad_digit;
    logic        seen_nonzero;

    uuidp_pkg::out_item_t parsed_uuid_q[$];

    task automatic clear_parse();
        char_pos = '0;
        high_nib = '0;
        bytes_hi = '0;
        bytes_lo = '0;
        bad_form = 1'b0;
        bad_digit = 1'b0;
        seen_nonzero = 1'b0;
    endtask

    task automatic parse_char(input uuidp_pkg::in_item_t it);
        logic [5:0] pos;
        logic [5:0] didx;
        logic [3:0] nib;
        logic [7:0] c;
        logic [3:0] ver;
        logic       ver_ok;
        uuidp_pkg::out_item_t res;
        pos = char_pos;
        c = it.char_code;
        if (pos >= 6'(uuidp_pkg::TEXT_LEN)) begin
            bad_form = 1'b1;
        end else if (pos == 6'd8 || pos == 6'd13 || pos == 6'd18 || pos == 6'd23) begin
            if (c != uuidp_pkg::CHAR_HYPHEN)
                bad_form = 1'b1;
        end else begin
            // '0'..'9', then 'a'..'f' / 'A'..'F'
            if (c >= 8'h30 && c <= 8'h39) begin
                nib = c[3:0];
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                nib = c[3:0] + uuidp_pkg::HEX_ALPHA_OFS;
            end else begin
                nib = 4'd0;
                bad_digit = 1'b1;
            end
            if (nib != 4'd0)
                seen_nonzero = 1'b1;
            didx = pos - 6'(pos > 6'd8) - 6'(pos > 6'd13) - 6'(pos > 6'd18)
                   - 6'(pos > 6'd23);
            if (!didx[0]) begin
                high_nib = nib;
            end else begin
                bytes_hi = {bytes_hi[55:0], bytes_lo[63:56]};
                bytes_lo = {bytes_lo[55:0], high_nib, nib};
                high_nib = 4'd0;
            end
        end
        if (char_pos != uuidp_pkg::POS_MAX)
            char_pos = char_pos + 6'd1;
        if (it.last) begin
            if (pos != uuidp_pkg::POS_LAST)
                bad_form = 1'b1;
            ver = bytes_hi[15:12];
            ver_ok = (ver == 4'd1) || (ver >= 4'd3 && ver <= 4'd8);
            res.uuid_high = bytes_hi;
            res.uuid_low = bytes_lo;
            res.version_nibble = ver;
            if (bad_form) begin
                res.status = uuidp_pkg::STATUS_FORM;
            end else if (bad_digit) begin
                res.status = uuidp_pkg::STATUS_DIGIT;
            end else if (seen_nonzero && ver_ok
                         && (bytes_lo[63:56] & uuidp_pkg::VARIANT_MASK)
                            == uuidp_pkg::VARIANT_RFC) begin
                res.status = uuidp_pkg::STATUS_OK;
            end else begin
                res.status = uuidp_pkg::STATUS_INVALID;
            end
            if (res.status == uuidp_pkg::STATUS_FORM
                || res.status == uuidp_pkg::STATUS_DIGIT) begin
                res.uuid_high = '0;
                res.uuid_low = '0;
                res.version_nibble = '0;
            end
            parsed_uuid_q = {parsed_uuid_q, res};
            clear_parse();
        end
    endtask

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        uuidp_pkg::out_item_t want;
        if (!aresetn) begin
            clear_parse();
            parsed_uuid_q.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (parsed_uuid_q.size() == 0) begin
                    $display("%0t: result with none pending, expected nothing, got %h",
                             $time, m_item);
                    fail_count++;
                end else begin
                    want = parsed_uuid_q.pop_front();
                    compare_field("uuid_high", want.uuid_high, m_item.uuid_high);
                    compare_field("uuid_low", want.uuid_low, m_item.uuid_low);
                    compare_field("version_nibble", 64'(want.version_nibble),
                                  64'(m_item.version_nibble));
                    compare_field("status", 64'(want.status), 64'(m_item.status));
                end
            end
            if (s_valid && s_ready)
                parse_char(s_item);
        end
        expected_count = parsed_uuid_q.size();
    end

endmodule

### test/uuid_text_parser_top_tb.sv
module uuid_text_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 200;
    localparam int RANDOM_ITEMS = 1900;
    localparam int QUIET_FROM = 1600;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    uuidp_pkg::in_item_t  s_item;
    logic                 m_valid;
    logic                 m_ready;
    uuidp_pkg::out_item_t m_item;

    int fail_count;
    int expected_count;
    int cycle_count = 0;
    int sent_items = 0;
    int hold_requests = 0;
    int holds_done = 0;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;

    logic [7:0] text_q[$];
    logic [3:0] digits[32];
    logic [3:0] good_versions[7] = '{4'd1, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8};

    uuid_text_parser_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    uuid_text_parser_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .fail_count     (fail_count),
        .expected_count (expected_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random back-pressure bursts and the requested long hold
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return (upper ? 8'h41 : 8'h61) + 8'(nib - 4'd10);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // 8-4-4-4-12 text from digits[], case lower, upper or picked per character
    task automatic render_uuid(input int case_mode);
        int k;
        k = 0;
        text_q.delete();
        for (int p = 0; p < uuidp_pkg::TEXT_LEN; p++) begin
            if (p == 8 || p == 13 || p == 18 || p == 23) begin
                text_q = {text_q, uuidp_pkg::CHAR_HYPHEN};
            end else begin
                text_q = {text_q, hex_char(digits[k],
                    case_mode == 2 ? bit'($urandom_range(0, 1)) : bit'(case_mode))};
                k++;
            end
        end
    endtask

    task automatic random_digits();
        for (int i = 0; i < 32; i++)
            digits[i] = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 4) != 0)
            digits[12] = good_versions[$urandom_range(0, 6)];
        if ($urandom_range(0, 4) != 0)
            digits[16] = 4'(8 + $urandom_range(0, 3));
    endtask

    task automatic push_char(input logic [7:0] c, input logic is_last);
        s_valid <= 1'b1;
        s_item <= '{char_code: c, last: is_last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            push_char(text_q[i], i == text_q.size() - 1);
            if (tx_idle_on && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (expected_count == 0);
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int pick;
        bit paused;
        paused = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // single characters flagged last: too short
        text_q = '{8'h00};
        send_text();
        text_q = '{8'hFF};
        send_text();
        // nil value
        foreach (digits[i]) digits[i] = 4'h0;
        render_uuid(0);
        send_text();
        // all ones apart from version 8 and RFC variant, upper case
        foreach (digits[i]) digits[i] = 4'hF;
        digits[12] = 4'd8;
        digits[16] = 4'hB;
        render_uuid(1);
        send_text();
        // version 2 is rejected, version 0 too
        digits[12] = 4'd2;
        render_uuid(0);
        send_text();
        digits[12] = 4'd0;
        render_uuid(2);
        send_text();
        // wrong variant
        digits[12] = 4'd4;
        digits[16] = 4'h7;
        render_uuid(0);
        send_text();
        digits[16] = 4'hC;
        render_uuid(0);
        send_text();
        // hyphen where a digit belongs
        digits[16] = 4'h9;
        render_uuid(2);
        text_q[0] = uuidp_pkg::CHAR_HYPHEN;
        send_text();
        // non-hex byte in a digit
        render_uuid(2);
        text_q[35] = 8'hFF;
        send_text();
        // wrong character at a hyphen slot
        render_uuid(0);
        text_q[23] = 8'h30;
        send_text();
        // form error beats digit error
        render_uuid(0);
        text_q[2] = 8'h67;
        text_q[13] = 8'h78;
        send_text();
        // 35 and 37 characters
        render_uuid(0);
        void'(text_q.pop_back());
        send_text();
        render_uuid(0);
        text_q = {text_q, 8'h30};
        send_text();
        // position counter saturation
        text_q.delete();
        repeat (70) text_q = {text_q, any_byte()};
        send_text();
        drain();

        while (sent_items < RANDOM_ITEMS) begin
            if (sent_items < QUIET_FROM) begin
                tx_idle_on = bit'($urandom_range(0, 1));
                rx_idle_on = bit'($urandom_range(0, 1));
            end else begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (hold_requests == 0 && sent_items >= 500) begin
                hold_requests++;
                tx_idle_on = 1'b0;
            end
            if (!paused && sent_items >= 1000) begin
                drain();
                paused = 1'b1;
            end

            random_digits();
            if ($urandom_range(0, 29) == 0)
                foreach (digits[i]) digits[i] = 4'h0;
            render_uuid(2);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // well formed as is
            end else if (pick < 68) begin
                text_q[$urandom_range(0, uuidp_pkg::TEXT_LEN - 1)] = any_byte();
            end else if (pick < 73) begin
                pick = $urandom_range(0, uuidp_pkg::TEXT_LEN - 1);
                if (pick == 8 || pick == 13 || pick == 18 || pick == 23)
                    pick++;
                text_q[pick] = uuidp_pkg::CHAR_HYPHEN;
            end else if (pick < 78) begin
                case ($urandom_range(0, 3))
                    0: text_q[8] = any_byte();
                    1: text_q[13] = any_byte();
                    2: text_q[18] = any_byte();
                    default: text_q[23] = any_byte();
                endcase
            end else if (pick < 84) begin
                pick = $urandom_range(1, uuidp_pkg::TEXT_LEN - 1);
                while (text_q.size() > pick) void'(text_q.pop_back());
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 30)) text_q = {text_q, any_byte()};
            end else begin
                text_q.delete();
                repeat ($urandom_range(1, 80)) text_q = {text_q, any_byte()};
            end
            send_text();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
sv/uuidp_pkg.sv
sv/uuidp_char_dec.sv
sv/uuidp_accum.sv
sv/uuid_text_parser_top.sv
test/uuid_text_parser_checker.sv
test/uuid_text_parser_top_tb.sv
